// ===== rtl/tcl_pkg.sv =====
// tcl_pkg: word types, register indexes and reset values for the touch code lock
// no dependencies; imported by touch_code_lock
package tcl_pkg;

	localparam int CodeWidth    = 44;
	localparam int CfgWidth     = 44;
	localparam int CfgIdxWidth  = 3;
	localparam int CodePositions = 11;

	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_CODE_DIGITS   = 3'd0,
		CFG_CODE_LENGTH   = 3'd1,
		CFG_ENTRY_TIME    = 3'd2,
		CFG_UNLOCK_TIME   = 3'd3,
		CFG_ESC_HOLDOFF   = 3'd4
	} cfg_idx_t;

	localparam logic [CodeWidth-1:0] CodeDigitsReset = 44'd5666190545953;
	localparam logic [3:0]           CodeLengthReset = 4'd11;
	localparam logic [15:0]          EntryTimeReset  = 16'd10000;
	localparam logic [23:0]          UnlockTimeReset = 24'd60000;
	localparam logic [15:0]          HoldoffReset    = 16'd3000;

	typedef struct packed {
		logic [7:0] pad_mask_a;
		logic [7:0] pad_mask_b;
		logic       hold_level;
	} in_word_t;

	typedef struct packed {
		logic       unlocked;
		logic [3:0] progress;
		logic       wrong_entry;
		logic       escalate;
		logic       confirm_light;
	} out_word_t;

endpackage

// ===== rtl/touch_code_lock.sv =====
// touch_code_lock: sequence code lock with entry timeout and escalation holdoff
// depends on tcl_pkg for word types, register indexes and reset values
//
// channel  dir  handshake             word
// in       in   in_valid / in_ready   tcl_pkg::in_word_t (pad masks, hold level)
// out      out  out_valid / out_ready tcl_pkg::out_word_t (one result per accepted word)
// cfg      in   cfg_we                cfg_index, cfg_data
//
// one word per cycle while the output is not stalled: the state update and the result are one pass of compares,
// a priority encode and saturating counters between the state and result registers.
// the result is registered: out_valid rises in the cycle after acceptance.
// in_ready is high whenever the result register is empty or being taken, so a
// stall on the output side holds the input only while a result waits.
// reset clears the lock state and out_valid and loads the register reset values.
module touch_code_lock #(
	parameter int MAX_DIGITS      = 11,
	parameter int PADS_PER_SENSOR = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tcl_pkg::in_word_t               in_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tcl_pkg::out_word_t              out_word,
	input  logic                            cfg_we,
	input  logic [tcl_pkg::CfgIdxWidth-1:0] cfg_index,
	input  logic [tcl_pkg::CfgWidth-1:0]    cfg_data
);
	import tcl_pkg::*;

	localparam logic [4:0] MaxLen = 5'(MAX_DIGITS);

	// configuration registers
	logic [CodeWidth-1:0] code_q;
	logic [3:0]           len_q;
	logic [15:0]          entry_time_q;
	logic [23:0]          unlock_time_q;
	logic [15:0]          holdoff_q;

	// lock state
	logic [3:0]  dc_q, pd_q;
	logic        er_q, wait_q, kr_q, open_q;
	logic [15:0] ee_q, se_q;
	logic [23:0] oe_q;

	logic        out_valid_q;
	out_word_t   out_q;

	logic        accept;

	logic [7:0]  pad_ok;
	logic [7:0]  ma, mb;
	logic [3:0]  ka, kb;
	logic        ta, tb;
	logic [4:0]  len;
	logic [3:0]  code_digit;

	logic [3:0]  dc_d, pd_d;
	logic        er_d, wait_d, kr_d, open_d;
	logic [15:0] ee_d, se_d;
	logic [23:0] oe_d;
	logic        wr_d, esc_d, go_wrong;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pad_ok[i] = (i < PADS_PER_SENSOR);
		end
	end

	assign ma = in_word.pad_mask_a & pad_ok;
	assign mb = in_word.pad_mask_b & pad_ok;
	assign ta = (ma != '0);
	assign tb = (mb != '0);

	// lowest touched pad, numbered from one
	always_comb begin
		ka = '0;
		kb = '0;
		for (int i = 7; i >= 0; i--) begin
			if (ma[i]) ka = 4'(i + 1);
			if (mb[i]) kb = 4'(i + 1);
		end
	end

	always_comb begin
		len = {1'b0, len_q};
		if (len == '0) len = 5'd1;
		if (len > MaxLen) len = MaxLen;
	end

	// expected digit at the current position, zero past the code
	always_comb begin
		code_digit = '0;
		for (int i = 0; i < CodePositions; i++) begin
			if (dc_q == 4'(i)) code_digit = code_q[4*i +: 4];
		end
	end

	always_comb begin
		dc_d     = dc_q;
		pd_d     = pd_q;
		er_d     = er_q;
		wait_d   = wait_q;
		kr_d     = kr_q;
		open_d   = open_q;
		ee_d     = (er_q && ee_q != 16'hFFFF) ? ee_q + 16'd1 : ee_q;
		oe_d     = (open_q && oe_q != 24'hFFFFFF) ? oe_q + 24'd1 : oe_q;
		se_d     = (se_q != 16'hFFFF) ? se_q + 16'd1 : se_q;
		wr_d     = 1'b0;
		esc_d    = 1'b0;
		go_wrong = 1'b0;

		if (open_d && oe_d > unlock_time_q) begin
			open_d = 1'b0;
			kr_d   = 1'b0;
		end

		if (!in_word.hold_level) begin
			if (wait_q) begin
				if (!ta && !tb) begin
					wait_d = 1'b0;
					ee_d   = '0;
					if ({1'b0, dc_q} >= len) begin
						open_d = 1'b1;
						oe_d   = '0;
						dc_d   = '0;
						pd_d   = '0;
						er_d   = 1'b0;
					end
				end
			end else if (er_q && ee_d > entry_time_q) begin
				go_wrong = 1'b1;
			end else if (ta || tb) begin
				if (!er_q) begin
					er_d = 1'b1;
					ee_d = '0;
				end
				if (ee_d >= entry_time_q) begin
					go_wrong = 1'b1;
				end else if (ta && tb) begin
					kr_d = 1'b1;
					if (ka != kb) begin
						go_wrong = 1'b1;
					end else if (ka != pd_q) begin
						if (ka == code_digit) begin
							pd_d   = ka;
							dc_d   = dc_q + 4'd1;
							wait_d = 1'b1;
						end else begin
							go_wrong = 1'b1;
						end
					end
				end
			end
		end

		if (go_wrong) begin
			dc_d = '0;
			pd_d = '0;
			er_d = 1'b0;
			wr_d = 1'b1;
			if (!open_d && kr_d && se_d > holdoff_q) begin
				esc_d = 1'b1;
				se_d  = '0;
			end
			kr_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q        <= CodeDigitsReset;
			len_q         <= CodeLengthReset;
			entry_time_q  <= EntryTimeReset;
			unlock_time_q <= UnlockTimeReset;
			holdoff_q     <= HoldoffReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CODE_DIGITS: code_q        <= cfg_data[CodeWidth-1:0];
				CFG_CODE_LENGTH: len_q         <= cfg_data[3:0];
				CFG_ENTRY_TIME:  entry_time_q  <= cfg_data[15:0];
				CFG_UNLOCK_TIME: unlock_time_q <= cfg_data[23:0];
				CFG_ESC_HOLDOFF: holdoff_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q   <= '0;
			pd_q   <= '0;
			er_q   <= 1'b0;
			wait_q <= 1'b0;
			kr_q   <= 1'b0;
			open_q <= 1'b0;
			ee_q   <= '0;
			oe_q   <= '0;
			se_q   <= '0;
		end else if (accept) begin
			dc_q   <= dc_d;
			pd_q   <= pd_d;
			er_q   <= er_d;
			wait_q <= wait_d;
			kr_q   <= kr_d;
			open_q <= open_d;
			ee_q   <= ee_d;
			oe_q   <= oe_d;
			se_q   <= se_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.unlocked      <= open_d;
			out_q.progress      <= dc_d;
			out_q.wrong_entry   <= wr_d;
			out_q.escalate      <= esc_d;
			out_q.confirm_light <= wait_d;
		end
	end

	// escalation only comes with a wrong entry
	a_esc_wrong: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_word.escalate || out_word.wrong_entry))
		else $error("escalate without wrong_entry");

	// a wrong entry leaves no progress and no pending release
	a_wrong_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.wrong_entry) |-> (out_word.progress == '0
			&& !out_word.confirm_light))
		else $error("wrong entry kept progress");

	// progress never passes the code positions
	a_progress_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.progress <= 4'(CodePositions)))
		else $error("progress out of range");

	// a waiting result is never dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
		else $error("result lost under stall");

	// the state only moves on an accepted word
	a_state_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(dc_q) && $stable(se_q) && $stable(open_q)))
		else $error("state changed without a word");

endmodule
